[sv/nmac_pkg.sv]
// Package for the NLMS motion-artifact canceller: sizes, fixed-point constants,
// state and mode codes, and the control struct that the sequencer sends to the tap cells.
// Depends on nothing; every other file of the block refers to it by scoped names.
package nmac_pkg;

    // Fixed sizes of the block.
    localparam int TAPS         = 4;
    localparam int SAMPLE_WIDTH = 16;
    localparam int WEIGHT_WIDTH = 32;
    localparam int STEP_W       = 16;

    // Fraction bits of samples (Q1.x) and weights (Q2.x).
    localparam int FS = SAMPLE_WIDTH - 1;
    localparam int FW = WEIGHT_WIDTH - 2;

    // Datapath widths.
    localparam int PROD_W = WEIGHT_WIDTH + SAMPLE_WIDTH;            // w * x
    localparam int ACC_W  = PROD_W + $clog2(TAPS);                  // tap sum
    localparam int RND_W  = ACC_W - FW;                             // rounded tap sum
    localparam int DIF_W  = RND_W + 1;                              // desired minus sum
    localparam int SQ_W   = 2 * SAMPLE_WIDTH;                       // x * x
    localparam int POW_W  = 2 * SAMPLE_WIDTH + $clog2(TAPS);        // tap power plus eps
    localparam int MUE_W  = STEP_W + 1 + SAMPLE_WIDTH;              // step * error
    localparam int Q_W    = MUE_W + SAMPLE_WIDTH;                   // step * error * x
    localparam int SHL    = (FW >= STEP_W) ? FW - STEP_W : 0;
    localparam int SHR    = (FW < STEP_W) ? STEP_W - FW : 0;
    localparam int DVD_W  = Q_W + SHL;                              // dividend and quotient
    localparam int UPD_W  = DVD_W + 2;                              // weight plus delta
    localparam int CNT_W  = $clog2(DVD_W);

    // Regularizer: 1e-6 in the 2*FS fraction-bit scale of the tap power, at least 1.
    localparam longint unsigned EPS_RAW =
        ((64'd1 << (2 * FS)) + 64'd500000) / 64'd1000000;
    localparam longint unsigned EPS_UNITS = (EPS_RAW != 0) ? EPS_RAW : 64'd1;

    // Half an output LSB in the tap-sum scale, for round-half-up.
    localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (FW - 1);

    // Saturation limits.
    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_WIDTH-1){1'b1}}};
    localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_WIDTH-1){1'b0}}};

    // Configuration space.
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_STEP_SIZE = '0;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd328;

    // Filter modes; the unused code behaves as frozen.
    typedef enum logic [1:0] {
        MODE_BYPASS = 2'd0,
        MODE_ADAPT  = 2'd1,
        MODE_FROZEN = 2'd2
    } t_mode;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_ROUND,
        S_CLEAN,
        S_MUE,
        S_QMUL,
        S_DINIT,
        S_DIV,
        S_UPD,
        S_DONE
    } t_state;

    // Strobes from the sequencer to every tap cell.
    typedef struct packed {
        logic shift;    // shift the delay line by one sample
        logic mul;      // register w*x and x*x
        logic sum;      // move the partial sums one cell down the chain
        logic qmul;     // register step*error*x
        logic dinit;    // load the divider
        logic dstep;    // one quotient bit
        logic upd;      // write the saturated new weight
    } t_cell_ctrl;

endpackage

[sv/nmac_if.sv]
// Valid/ready channel interfaces for the input sample pair and the cleaned result.
// Depends on nmac_pkg for the field widths.
interface nmac_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [nmac_pkg::SAMPLE_WIDTH-1:0] desired_sample;
    logic signed [nmac_pkg::SAMPLE_WIDTH-1:0] reference_sample;
    logic                                    sample_present;
    logic [1:0]                              filter_mode;

    modport source (
        output valid, desired_sample, reference_sample, sample_present, filter_mode,
        input  ready
    );
    modport sink (
        input  valid, desired_sample, reference_sample, sample_present, filter_mode,
        output ready
    );
endinterface

interface nmac_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [nmac_pkg::SAMPLE_WIDTH-1:0] clean_sample;

    modport source (output valid, clean_sample, input ready);
    modport sink (input valid, clean_sample, output ready);
endinterface

[sv/nmac_cell.sv]
// One tap cell of the canceller: delay-line stage, weight, products, a link of the
// partial-sum chain and a bit-serial divider for the normalized weight update.
// Depends on nmac_pkg.
module nmac_cell (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  nmac_pkg::t_cell_ctrl                   i_ctrl,
    input  logic signed [nmac_pkg::SAMPLE_WIDTH-1:0] i_tap,
    input  logic signed [nmac_pkg::ACC_W-1:0]       i_psum,
    input  logic [nmac_pkg::POW_W-1:0]              i_pwr,
    input  logic signed [nmac_pkg::MUE_W-1:0]       i_mue,
    input  logic [nmac_pkg::POW_W-1:0]              i_div,
    output logic signed [nmac_pkg::SAMPLE_WIDTH-1:0] o_tap,
    output logic signed [nmac_pkg::ACC_W-1:0]       o_psum,
    output logic [nmac_pkg::POW_W-1:0]              o_pwr
);

    logic signed [nmac_pkg::SAMPLE_WIDTH-1:0] r_tap;
    logic signed [nmac_pkg::WEIGHT_WIDTH-1:0] r_weight;
    logic signed [nmac_pkg::WEIGHT_WIDTH-1:0] n_weight;
    logic signed [nmac_pkg::PROD_W-1:0]       r_prod;
    logic signed [nmac_pkg::PROD_W-1:0]       n_prod;
    logic [nmac_pkg::SQ_W-1:0]                r_sq;
    logic signed [nmac_pkg::SQ_W-1:0]         n_sq;
    logic signed [nmac_pkg::ACC_W-1:0]        r_psum;
    logic [nmac_pkg::POW_W-1:0]               r_pwr;
    logic signed [nmac_pkg::Q_W-1:0]          r_q;
    logic signed [nmac_pkg::Q_W-1:0]          n_q;
    logic                                     r_neg;
    logic [nmac_pkg::DVD_W-1:0]               r_dvd;
    logic [nmac_pkg::DVD_W-1:0]               n_dvd_init;
    logic [nmac_pkg::POW_W-1:0]               r_rem;
    logic [nmac_pkg::POW_W-1:0]               n_rem;
    logic [nmac_pkg::Q_W-1:0]                 w_mag;
    logic [nmac_pkg::POW_W:0]                 w_trial;
    logic                                     w_qbit;
    logic signed [nmac_pkg::UPD_W-1:0]        w_delta;
    logic signed [nmac_pkg::UPD_W-1:0]        w_wsum;
    logic                                     w_fits;

    assign o_tap  = r_tap;
    assign o_psum = r_psum;
    assign o_pwr  = r_pwr;

    // Products of this tap.
    assign n_prod = r_weight * r_tap;
    assign n_sq   = r_tap * r_tap;
    assign n_q    = i_mue * r_tap;

    // Magnitude of step*error*x, scaled to the weight fraction.
    assign w_mag = r_q[nmac_pkg::Q_W-1] ? nmac_pkg::Q_W'(-r_q) : nmac_pkg::Q_W'(r_q);
    assign n_dvd_init = (nmac_pkg::FW >= nmac_pkg::STEP_W)
                      ? (nmac_pkg::DVD_W'(w_mag) << nmac_pkg::SHL)
                      : nmac_pkg::DVD_W'(w_mag >> nmac_pkg::SHR);

    // Restoring division: the dividend shifts out of r_dvd as quotient bits shift in.
    assign w_trial = {r_rem, r_dvd[nmac_pkg::DVD_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, i_div});
    assign n_rem   = w_qbit ? nmac_pkg::POW_W'(w_trial - {1'b0, i_div})
                            : w_trial[nmac_pkg::POW_W-1:0];

    // New weight with the sign applied to the truncated quotient, then saturated.
    assign w_delta = r_neg ? -$signed({2'b00, r_dvd}) : $signed({2'b00, r_dvd});
    assign w_wsum  = nmac_pkg::UPD_W'(r_weight) + w_delta;
    assign w_fits  = (&w_wsum[nmac_pkg::UPD_W-1:nmac_pkg::WEIGHT_WIDTH-1])
                   | ~(|w_wsum[nmac_pkg::UPD_W-1:nmac_pkg::WEIGHT_WIDTH-1]);
    assign n_weight = w_fits ? $signed(w_wsum[nmac_pkg::WEIGHT_WIDTH-1:0])
                    : (w_wsum[nmac_pkg::UPD_W-1] ? $signed(nmac_pkg::WEIGHT_MIN)
                                                 : $signed(nmac_pkg::WEIGHT_MAX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap    <= '0;
            r_weight <= '0;
        end else begin
            if (i_ctrl.shift) begin
                r_tap <= i_tap;
            end
            if (i_ctrl.upd) begin
                r_weight <= n_weight;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            r_prod <= n_prod;
            r_sq   <= n_sq;
        end
        if (i_ctrl.sum) begin
            r_psum <= i_psum + nmac_pkg::ACC_W'(r_prod);
            r_pwr  <= i_pwr + nmac_pkg::POW_W'(r_sq);
        end
        if (i_ctrl.qmul) begin
            r_q <= n_q;
        end
        if (i_ctrl.dinit) begin
            r_neg <= r_q[nmac_pkg::Q_W-1];
            r_dvd <= n_dvd_init;
            r_rem <= '0;
        end else if (i_ctrl.dstep) begin
            r_dvd <= {r_dvd[nmac_pkg::DVD_W-2:0], w_qbit};
            r_rem <= n_rem;
        end
    end

    // The weight only moves in the update cycle of an adapting sample.
    a_weight_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctrl.upd |=> $stable(r_weight))
        else $error("tap weight changed outside the update cycle");

    // The delay line only moves when a valid sample is taken.
    a_tap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctrl.shift |=> $stable(r_tap))
        else $error("delay line moved without a sample");

    // After each quotient step the partial remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.dstep |=> (r_rem < i_div))
        else $error("divider remainder not below the tap power");

endmodule

[sv/nmac_cfg.sv]
// APB-style configuration register file of the canceller: holds the adaptation step.
// Depends on nmac_pkg.
module nmac_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nmac_pkg::PADDR_W-1:0]      paddr,
    input  logic [nmac_pkg::PDATA_W-1:0]      pwdata,
    output logic [nmac_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    output logic [nmac_pkg::STEP_W-1:0]       o_step
);

    logic [nmac_pkg::STEP_W-1:0]    r_step;
    logic [nmac_pkg::REG_IDX_W-1:0] w_idx;
    logic                           w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[nmac_pkg::PADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_step = r_step;

    always_comb begin
        prdata = '0;
        if (w_idx == nmac_pkg::REG_STEP_SIZE) begin
            prdata = nmac_pkg::PDATA_W'(r_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= nmac_pkg::STEP_RESET;
        end else if (w_wr && (w_idx == nmac_pkg::REG_STEP_SIZE)) begin
            r_step <= pwdata[nmac_pkg::STEP_W-1:0];
        end
    end

endmodule

[sv/nlms_motion_artifact_canceller.sv]
// NLMS motion-artifact canceller: a row of TAPS tap cells driven by one sequencer.
// Each transfer on the input channel carries a PPG sample, an accelerometer sample, a
// valid flag and a mode; each one yields exactly one cleaned sample on the output
// channel. An invalid sample gives 0 and leaves the filter untouched. A valid sample
// enters the delay line; bypass returns the PPG sample, frozen subtracts the weighted
// tap sum (rounded to Q1.15, saturated), and adapt also moves every weight by
// step*error*tap/(tap power + eps), truncated toward zero and saturated to Q2.30.
// Mode code 3 acts as frozen. The block takes one sample at a time: an invalid or
// bypass sample goes straight to the result stage, a frozen one first passes the
// partial tap sum down the row one cell per cycle, and an adapting one then also runs
// the one-bit-per-cycle divider inside each cell; the cells all divide at once. A
// finished result waits in an output register, so the next sample is taken while the
// previous result has not yet been collected. The step size register (byte address 0,
// reset 328, about 0.005) is written over the APB-style port; the user must write it
// only while no sample is in flight, and the block itself does not enforce this.
// Depends on nmac_pkg, nmac_if, nmac_cell and nmac_cfg.
module nlms_motion_artifact_canceller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    nmac_in_if.sink                       i_in,
    nmac_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nmac_pkg::PADDR_W-1:0]  paddr,
    input  logic [nmac_pkg::PDATA_W-1:0]  pwdata,
    output logic [nmac_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int TAPS = nmac_pkg::TAPS;
    localparam int SW   = nmac_pkg::SAMPLE_WIDTH;

    // Sequencer and output control.
    nmac_pkg::t_state                 r_state;
    nmac_pkg::t_state                 n_state;
    logic [nmac_pkg::CNT_W-1:0]       r_cnt;
    logic                             r_out_valid;
    logic                             w_in_acc;
    logic                             w_out_load;
    nmac_pkg::t_cell_ctrl             w_ctrl;

    // Sample datapath held by the sequencer.
    logic signed [SW-1:0]             r_desired;
    logic [1:0]                       r_mode;
    logic signed [SW-1:0]             r_clean;
    logic signed [SW-1:0]             n_clean;
    logic signed [SW-1:0]             r_out_data;
    logic signed [nmac_pkg::RND_W-1:0] r_acc_rnd;
    logic [nmac_pkg::ACC_W-1:0]       w_acc_sum;
    logic signed [nmac_pkg::DIF_W-1:0] w_diff;
    logic                             w_diff_fits;
    logic signed [nmac_pkg::MUE_W-1:0] r_mue;
    logic signed [nmac_pkg::MUE_W-1:0] n_mue;
    logic [nmac_pkg::STEP_W-1:0]      w_step;

    // Links of the cell chain.
    logic signed [SW-1:0]             w_tap_in  [TAPS];
    logic signed [SW-1:0]             w_tap     [TAPS];
    logic signed [nmac_pkg::ACC_W-1:0] w_psum_in [TAPS];
    logic signed [nmac_pkg::ACC_W-1:0] w_psum    [TAPS];
    logic [nmac_pkg::POW_W-1:0]       w_pwr_in  [TAPS];
    logic [nmac_pkg::POW_W-1:0]       w_pwr     [TAPS];

    assign w_in_acc = i_in.valid && i_in.ready;

    // Configuration registers.
    nmac_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_step  (w_step)
    );

    // The row of tap cells. Cell 0 takes the new reference sample and starts the
    // partial sums (the power sum starts at eps); each further cell takes its
    // neighbor's tap and partial sums. Once the sum steps are done the last cell holds the
    // full weighted sum and the regularized tap power, which then stays put as the
    // divisor for every cell.
    for (genvar g = 0; g < TAPS; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_tap_in[g]  = i_in.reference_sample;
            assign w_psum_in[g] = '0;
            assign w_pwr_in[g]  = nmac_pkg::POW_W'(nmac_pkg::EPS_UNITS);
        end else begin : g_link
            assign w_tap_in[g]  = w_tap[g-1];
            assign w_psum_in[g] = w_psum[g-1];
            assign w_pwr_in[g]  = w_pwr[g-1];
        end

        nmac_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_tap   (w_tap_in[g]),
            .i_psum  (w_psum_in[g]),
            .i_pwr   (w_pwr_in[g]),
            .i_mue   (r_mue),
            .i_div   (w_pwr[TAPS-1]),
            .o_tap   (w_tap[g]),
            .o_psum  (w_psum[g]),
            .o_pwr   (w_pwr[g])
        );
    end

    // Round the tap sum half up to the sample scale: add half an LSB, keep the upper bits.
    assign w_acc_sum = w_psum[TAPS-1] + nmac_pkg::ACC_HALF;

    // Error sample: desired minus rounded sum, saturated to the sample range.
    assign w_diff      = nmac_pkg::DIF_W'(r_desired) - nmac_pkg::DIF_W'(r_acc_rnd);
    assign w_diff_fits = (&w_diff[nmac_pkg::DIF_W-1:SW-1]) | ~(|w_diff[nmac_pkg::DIF_W-1:SW-1]);
    assign n_clean     = w_diff_fits ? $signed(w_diff[SW-1:0])
                       : (w_diff[nmac_pkg::DIF_W-1] ? $signed(nmac_pkg::SAMPLE_MIN)
                                                    : $signed(nmac_pkg::SAMPLE_MAX));

    // Step times error, shared by all cells.
    assign n_mue = $signed({1'b0, w_step}) * r_clean;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nmac_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    if (!i_in.sample_present || (i_in.filter_mode == nmac_pkg::MODE_BYPASS)) begin
                        n_state = nmac_pkg::S_DONE;
                    end else begin
                        n_state = nmac_pkg::S_MUL;
                    end
                end
            end
            nmac_pkg::S_MUL:   n_state = nmac_pkg::S_SUM;
            nmac_pkg::S_SUM: begin
                if (r_cnt == nmac_pkg::CNT_W'(TAPS - 1)) begin
                    n_state = nmac_pkg::S_ROUND;
                end
            end
            nmac_pkg::S_ROUND: n_state = nmac_pkg::S_CLEAN;
            nmac_pkg::S_CLEAN: begin
                if (r_mode == nmac_pkg::MODE_ADAPT) begin
                    n_state = nmac_pkg::S_MUE;
                end else begin
                    n_state = nmac_pkg::S_DONE;
                end
            end
            nmac_pkg::S_MUE:   n_state = nmac_pkg::S_QMUL;
            nmac_pkg::S_QMUL:  n_state = nmac_pkg::S_DINIT;
            nmac_pkg::S_DINIT: n_state = nmac_pkg::S_DIV;
            nmac_pkg::S_DIV: begin
                if (r_cnt == nmac_pkg::CNT_W'(nmac_pkg::DVD_W - 1)) begin
                    n_state = nmac_pkg::S_UPD;
                end
            end
            nmac_pkg::S_UPD:   n_state = nmac_pkg::S_DONE;
            nmac_pkg::S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = nmac_pkg::S_IDLE;
                end
            end
            default:           n_state = nmac_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        w_ctrl       = '0;
        i_in.ready   = 1'b0;
        w_out_load   = 1'b0;
        unique case (r_state)
            nmac_pkg::S_IDLE: begin
                i_in.ready   = 1'b1;
                w_ctrl.shift = i_in.valid && i_in.sample_present;
            end
            nmac_pkg::S_MUL:   w_ctrl.mul   = 1'b1;
            nmac_pkg::S_SUM:   w_ctrl.sum   = 1'b1;
            nmac_pkg::S_QMUL:  w_ctrl.qmul  = 1'b1;
            nmac_pkg::S_DINIT: w_ctrl.dinit = 1'b1;
            nmac_pkg::S_DIV:   w_ctrl.dstep = 1'b1;
            nmac_pkg::S_UPD:   w_ctrl.upd   = 1'b1;
            nmac_pkg::S_DONE:  w_out_load   = !r_out_valid || o_out.ready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nmac_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == nmac_pkg::S_SUM) || (r_state == nmac_pkg::S_DIV)) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sample datapath. The accepted value of r_clean already is the answer for an
    // invalid sample (0) and for bypass (the desired sample); cancelling modes
    // overwrite it once the tap sum is known.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_desired <= i_in.desired_sample;
            r_mode    <= i_in.filter_mode;
            r_clean   <= i_in.sample_present ? i_in.desired_sample : '0;
        end
        if (r_state == nmac_pkg::S_ROUND) begin
            r_acc_rnd <= $signed(w_acc_sum[nmac_pkg::ACC_W-1:nmac_pkg::FW]);
        end
        if (r_state == nmac_pkg::S_CLEAN) begin
            r_clean <= n_clean;
        end
        if (r_state == nmac_pkg::S_MUE) begin
            r_mue <= n_mue;
        end
        if (w_out_load) begin
            r_out_data <= r_clean;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.clean_sample = r_out_data;

    // At most one cell operation is requested in any cycle.
    a_ctrl_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_ctrl))
        else $error("more than one cell operation requested");

    // An invalid sample goes straight to the result stage with a zero result.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_in.sample_present) |=> (r_state == nmac_pkg::S_DONE) && (r_clean == '0))
        else $error("invalid sample did not produce a zero result");

    // The weight update follows a complete division.
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nmac_pkg::S_UPD) |->
            ($past(r_state) == nmac_pkg::S_DIV)
            && ($past(r_cnt) == nmac_pkg::CNT_W'(nmac_pkg::DVD_W - 1)))
        else $error("weight update without a full division");

endmodule
